// File: rtl/core/activation_function_unit_core_assert.svh
`ifndef ACTIVATION_FUNCTION_UNIT_CORE_ASSERT_SVH
`define ACTIVATION_FUNCTION_UNIT_CORE_ASSERT_SVH

// assertion checked only while out of reset
`define AFU_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("activation unit assertion failed");

// assertion checked at every edge, reset included
`define AFU_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("activation unit assertion failed");

`endif

// File: rtl/core/afu_pkg.sv
package afu_pkg;

    localparam int DATA_WIDTH_DEF    = 16;
    localparam int SEG_ADDR_BITS_DEF = 6;

    localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;
    localparam int          EXP_HALF_PTS = 512;

    typedef enum logic [1:0] {
        FK_IDENTITY = 2'd0,
        FK_SIGMOID  = 2'd1,
        FK_TANH     = 2'd2
    } t_func_kind;

    typedef enum logic {
        OP_FORWARD  = 1'b0,
        OP_BACKWARD = 1'b1
    } t_opcode;

    typedef struct packed {
        logic       valid;
        t_opcode    opcode;
        t_func_kind kind;
    } t_item_ctrl;

    // sigmoid breakpoint k of 2^seg_bits+1 over [-8,8], frac_bits fraction bits
    function automatic logic [63:0] sig_point(input int k, input int seg_bits,
                                              input int frac_bits);
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        int          pos;
        int          mag;
        int          m;
        int          i;
        e   = 64'd1 << 32;
        pos = (k << (10 - seg_bits)) - EXP_HALF_PTS;
        mag = (pos < 0) ? -pos : pos;
        for (m = 1; m <= mag; m++) begin
            e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        den = (64'd1 << 32) + e;
        num = (64'd1 << (frac_bits + 32)) + (den >> 1);
        quo = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        if (pos < 0) begin
            return (64'd1 << frac_bits) - quo;
        end
        return quo;
    endfunction

endpackage

// File: rtl/core/afu_sig_lookup.sv
module afu_sig_lookup #(
    parameter int SEGMENT_ADDR_BITS = afu_pkg::SEG_ADDR_BITS_DEF,
    parameter int DATA_WIDTH        = afu_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  afu_pkg::t_item_ctrl          i_ctrl,
    input  logic signed [DATA_WIDTH-1:0] i_x,
    input  logic signed [DATA_WIDTH-1:0] i_g,
    output afu_pkg::t_item_ctrl          o_ctrl,
    output logic signed [DATA_WIDTH-1:0] o_x,
    output logic signed [DATA_WIDTH-1:0] o_g,
    output logic signed [DATA_WIDTH-3:0] o_act
);
    import afu_pkg::*;

    localparam int FRAC_BITS = DATA_WIDTH - 4;
    localparam int SEG_COUNT = 1 << SEGMENT_ADDR_BITS;
    localparam int SEG_SHIFT = DATA_WIDTH - SEGMENT_ADDR_BITS;
    localparam int TAB_W     = FRAC_BITS + 1;
    localparam int IDX_W     = SEGMENT_ADDR_BITS + 1;
    localparam int PROD_W    = TAB_W + SEG_SHIFT;
    localparam int ACT_W     = FRAC_BITS + 2;

    localparam logic [PROD_W:0] INTERP_HALF = (PROD_W + 1)'(1) << (SEG_SHIFT - 1);
    localparam logic signed [ACT_W-1:0] ONE_ACT = ACT_W'(1) << FRAC_BITS;

    logic [TAB_W-1:0] sig_tab [SEG_COUNT+1];

    for (genvar k = 0; k <= SEG_COUNT; k++) begin : g_tab
        assign sig_tab[k] = TAB_W'(sig_point(k, SEGMENT_ADDR_BITS, FRAC_BITS));
    end

    logic signed [DATA_WIDTH:0]   z;
    logic                         below;
    logic                         above;
    logic [DATA_WIDTH-1:0]        u;
    logic [SEGMENT_ADDR_BITS-1:0] seg;
    logic [IDX_W-1:0]             idx_lo;
    logic [IDX_W-1:0]             idx_hi;
    logic [SEG_SHIFT-1:0]         n_a_frac;

    // segment select, clamped outside [-8,8)
    always_comb begin
        if (i_ctrl.kind == FK_TANH) begin
            z = {i_x, 1'b0};
        end else begin
            z = {i_x[DATA_WIDTH-1], i_x};
        end
        below = z[DATA_WIDTH] & ~z[DATA_WIDTH-1];
        above = ~z[DATA_WIDTH] & z[DATA_WIDTH-1];
        u     = {~z[DATA_WIDTH-1], z[DATA_WIDTH-2:0]};
        seg   = u[DATA_WIDTH-1 -: SEGMENT_ADDR_BITS];
        if (below) begin
            idx_lo   = '0;
            idx_hi   = '0;
            n_a_frac = '0;
        end else if (above) begin
            idx_lo   = IDX_W'(SEG_COUNT);
            idx_hi   = IDX_W'(SEG_COUNT);
            n_a_frac = '0;
        end else begin
            idx_lo   = {1'b0, seg};
            idx_hi   = {1'b0, seg} + IDX_W'(1);
            n_a_frac = u[SEG_SHIFT-1:0];
        end
    end

    t_item_ctrl                   r_a_ctrl;
    logic signed [DATA_WIDTH-1:0] r_a_x;
    logic signed [DATA_WIDTH-1:0] r_a_g;
    logic [TAB_W-1:0]             r_a_base;
    logic [TAB_W-1:0]             r_a_step;
    logic [SEG_SHIFT-1:0]         r_a_frac;

    t_item_ctrl                   r_b_ctrl;
    logic signed [DATA_WIDTH-1:0] r_b_x;
    logic signed [DATA_WIDTH-1:0] r_b_g;
    logic [TAB_W-1:0]             r_b_base;
    logic [PROD_W-1:0]            r_b_prod;

    t_item_ctrl                   r_c_ctrl;
    logic signed [DATA_WIDTH-1:0] r_c_x;
    logic signed [DATA_WIDTH-1:0] r_c_g;
    logic signed [ACT_W-1:0]      r_c_act;

    logic [PROD_W:0]         rnd_sum;
    logic [TAB_W-1:0]        s_val;
    logic signed [ACT_W-1:0] n_c_act;

    // interpolate, then tanh = 2s - 1
    always_comb begin
        rnd_sum = {1'b0, r_b_prod} + INTERP_HALF;
        s_val   = r_b_base + TAB_W'(rnd_sum >> SEG_SHIFT);
        if (r_b_ctrl.kind == FK_TANH) begin
            n_c_act = $signed({s_val, 1'b0}) - ONE_ACT;
        end else begin
            n_c_act = $signed({1'b0, s_val});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl <= '0;
            r_b_ctrl <= '0;
            r_c_ctrl <= '0;
        end else begin
            r_a_ctrl <= i_ctrl;
            r_b_ctrl <= r_a_ctrl;
            r_c_ctrl <= r_b_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x    <= i_x;
        r_a_g    <= i_g;
        r_a_base <= sig_tab[idx_lo];
        r_a_step <= sig_tab[idx_hi] - sig_tab[idx_lo];
        r_a_frac <= n_a_frac;

        r_b_x    <= r_a_x;
        r_b_g    <= r_a_g;
        r_b_base <= r_a_base;
        r_b_prod <= PROD_W'(r_a_step) * PROD_W'(r_a_frac);

        r_c_x    <= r_b_x;
        r_c_g    <= r_b_g;
        r_c_act  <= n_c_act;
    end

    assign o_ctrl = r_c_ctrl;
    assign o_x    = r_c_x;
    assign o_g    = r_c_g;
    assign o_act  = r_c_act;

endmodule

// File: rtl/core/afu_deriv.sv
module afu_deriv #(
    parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  afu_pkg::t_item_ctrl          i_ctrl,
    input  logic signed [DATA_WIDTH-1:0] i_x,
    input  logic signed [DATA_WIDTH-1:0] i_g,
    input  logic signed [DATA_WIDTH-3:0] i_act,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_result
);
    import afu_pkg::*;

    localparam int FRAC_BITS = DATA_WIDTH - 4;
    localparam int ACT_W     = FRAC_BITS + 2;
    localparam int DPROD_W   = 2 * ACT_W;
    localparam int GPROD_W   = DATA_WIDTH + ACT_W;
    localparam int PRE_W     = DATA_WIDTH + 2;

    localparam logic signed [ACT_W-1:0]   ONE_ACT = ACT_W'(1) << FRAC_BITS;
    localparam logic signed [DPROD_W-1:0] D_HALF  = DPROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [GPROD_W-1:0] G_HALF  = GPROD_W'(1) << (FRAC_BITS - 1);

    t_item_ctrl                   r_d_ctrl;
    logic signed [DATA_WIDTH-1:0] r_d_x;
    logic signed [DATA_WIDTH-1:0] r_d_g;
    logic signed [ACT_W-1:0]      r_d_act;
    logic signed [DPROD_W-1:0]    r_d_prod;

    t_item_ctrl                   r_e_ctrl;
    logic signed [DATA_WIDTH-1:0] r_e_x;
    logic signed [DATA_WIDTH-1:0] r_e_g;
    logic signed [ACT_W-1:0]      r_e_act;
    logic signed [ACT_W-1:0]      r_e_d;

    t_item_ctrl                   r_f_ctrl;
    logic signed [DATA_WIDTH-1:0] r_f_x;
    logic signed [DATA_WIDTH-1:0] r_f_g;
    logic signed [ACT_W-1:0]      r_f_act;
    logic signed [GPROD_W-1:0]    r_f_prod;

    logic                         r_g_valid;
    logic signed [DATA_WIDTH-1:0] r_g_result;

    logic signed [ACT_W-1:0]      opb;
    logic signed [DPROD_W-1:0]    d_sum;
    logic signed [ACT_W-1:0]      d_rnd;
    logic signed [ACT_W-1:0]      n_e_d;
    logic signed [GPROD_W-1:0]    g_sum;
    logic signed [PRE_W-1:0]      g_full;
    logic signed [PRE_W-1:0]      pre;
    logic signed [DATA_WIDTH-1:0] n_g_result;

    // s*(1-s) for sigmoid, t*t for tanh
    always_comb begin
        if (i_ctrl.kind == FK_SIGMOID) begin
            opb = ONE_ACT - i_act;
        end else begin
            opb = i_act;
        end
    end

    always_comb begin
        d_sum = r_d_prod + D_HALF;
        d_rnd = ACT_W'(d_sum >>> FRAC_BITS);
        if (r_d_ctrl.kind == FK_SIGMOID) begin
            n_e_d = d_rnd;
        end else begin
            n_e_d = ONE_ACT - d_rnd;
        end
    end

    // final rounding, select and saturate
    always_comb begin
        g_sum  = r_f_prod + G_HALF;
        g_full = PRE_W'(g_sum >>> FRAC_BITS);
        case (r_f_ctrl.kind)
            FK_SIGMOID, FK_TANH: begin
                if (r_f_ctrl.opcode == OP_BACKWARD) begin
                    pre = g_full;
                end else begin
                    pre = PRE_W'(r_f_act);
                end
            end
            default: begin
                if (r_f_ctrl.opcode == OP_BACKWARD) begin
                    pre = PRE_W'(r_f_g);
                end else begin
                    pre = PRE_W'(r_f_x);
                end
            end
        endcase
        if (pre[PRE_W-1:DATA_WIDTH-1] == '0 || pre[PRE_W-1:DATA_WIDTH-1] == '1) begin
            n_g_result = pre[DATA_WIDTH-1:0];
        end else if (pre[PRE_W-1]) begin
            n_g_result = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            n_g_result = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctrl  <= '0;
            r_e_ctrl  <= '0;
            r_f_ctrl  <= '0;
            r_g_valid <= 1'b0;
        end else begin
            r_d_ctrl  <= i_ctrl;
            r_e_ctrl  <= r_d_ctrl;
            r_f_ctrl  <= r_e_ctrl;
            r_g_valid <= r_f_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_x      <= i_x;
        r_d_g      <= i_g;
        r_d_act    <= i_act;
        r_d_prod   <= DPROD_W'(i_act) * DPROD_W'(opb);

        r_e_x      <= r_d_x;
        r_e_g      <= r_d_g;
        r_e_act    <= r_d_act;
        r_e_d      <= n_e_d;

        r_f_x      <= r_e_x;
        r_f_g      <= r_e_g;
        r_f_act    <= r_e_act;
        r_f_prod   <= GPROD_W'(r_e_g) * GPROD_W'(r_e_d);

        r_g_result <= n_g_result;
    end

    assign o_valid  = r_g_valid;
    assign o_result = r_g_result;

endmodule

// File: rtl/core/activation_function_unit_core.sv
// throughput: one request per clock, busy is always low since every stage advances each cycle
// the pipeline has 8 stages: input register, table read, interpolation multiply,
// interpolate, derivative multiply, derivative round, gradient multiply, round and saturate
// reset (synchronous, active low) empties the pipeline and sets function_kind to identity
module activation_function_unit_core #(
    parameter int SEGMENT_ADDR_BITS = afu_pkg::SEG_ADDR_BITS_DEF,
    parameter int DATA_WIDTH        = afu_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic signed [DATA_WIDTH-1:0] i_x_value,
    input  logic signed [DATA_WIDTH-1:0] i_grad_in,
    output logic                         o_result_valid,
    output logic signed [DATA_WIDTH-1:0] o_result_value
);
    import afu_pkg::*;

    t_func_kind                   r_function_kind;
    t_item_ctrl                   r_in_ctrl;
    t_item_ctrl                   n_in_ctrl;
    logic signed [DATA_WIDTH-1:0] r_in_x;
    logic signed [DATA_WIDTH-1:0] r_in_g;

    t_item_ctrl                   lk_ctrl;
    logic signed [DATA_WIDTH-1:0] lk_x;
    logic signed [DATA_WIDTH-1:0] lk_g;
    logic signed [DATA_WIDTH-3:0] lk_act;

    assign busy = 1'b0;

    always_comb begin
        n_in_ctrl.valid  = start && !busy;
        n_in_ctrl.opcode = t_opcode'(i_opcode);
        n_in_ctrl.kind   = r_function_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_function_kind <= FK_IDENTITY;
            r_in_ctrl       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_function_kind <= t_func_kind'(i_cfg_wdata);
            end
            r_in_ctrl <= n_in_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_x <= i_x_value;
            r_in_g <= i_grad_in;
        end
    end

    afu_sig_lookup #(
        .SEGMENT_ADDR_BITS (SEGMENT_ADDR_BITS),
        .DATA_WIDTH        (DATA_WIDTH)
    ) u_sig_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_in_ctrl),
        .i_x     (r_in_x),
        .i_g     (r_in_g),
        .o_ctrl  (lk_ctrl),
        .o_x     (lk_x),
        .o_g     (lk_g),
        .o_act   (lk_act)
    );

    afu_deriv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_deriv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (lk_ctrl),
        .i_x      (lk_x),
        .i_g      (lk_g),
        .i_act    (lk_act),
        .o_valid  (o_result_valid),
        .o_result (o_result_value)
    );

endmodule

// File: rtl/core/afu_checker.sv
`include "activation_function_unit_core_assert.svh"

module afu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid
);
    localparam int LATENCY = 8;

    `AFU_ASSERT_ANY(a_never_busy, i_clk, !busy)

    `AFU_ASSERT_RST(a_result_has_request, i_clk, i_rst_n,
        o_result_valid |-> $past(start && !busy && i_rst_n, LATENCY))

    `AFU_ASSERT_ANY(a_reset_clears_strobe, i_clk, !i_rst_n |=> !o_result_valid)

endmodule

bind activation_function_unit_core afu_checker u_afu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid)
);
